/* hw/rtl/mmp_pkg.sv */
// ----------------------------------------------------------------------------
// mmp_pkg: shared types and constants of the midi message parser
// byte codes, status codes, event kinds and the channel to voice map
// ----------------------------------------------------------------------------
package mmp_pkg;

   // link byte codes
   localparam logic [7:0] BYTE_ESCAPE   = 8'hFF;
   localparam logic [7:0] BYTE_FILLER   = 8'hFE;
   localparam logic [7:0] REALTIME_MASK = 8'hF8;

   // status codes with the channel nibble cleared, last channel status, none
   localparam logic [7:0] ST_NOTE_OFF   = 8'h80;
   localparam logic [7:0] ST_NOTE_ON    = 8'h90;
   localparam logic [7:0] ST_CONTROL    = 8'hB0;
   localparam logic [7:0] ST_PROGRAM    = 8'hC0;
   localparam logic [7:0] ST_PRESSURE   = 8'hD0;
   localparam logic [7:0] ST_PITCH      = 8'hE0;
   localparam logic [7:0] ST_LAST_CHAN  = 8'hEF;
   localparam logic [7:0] ST_NONE       = 8'h00;

   // controllers that mean all sound off
   localparam logic [7:0] CC_SOUND_OFF  = 8'd120;
   localparam logic [7:0] CC_NOTES_OFF  = 8'd123;

   localparam logic [15:0] PITCH_LIMIT  = 16'h4000;

   localparam int CHAN_SETS  = 4;
   localparam int MAP_VOICES = 5;

   typedef logic [1:0] chan_set_type;

   typedef enum logic [1:0] {
      EV_NOTE      = 2'd0,
      EV_CONTROL   = 2'd1,
      EV_SOUND_OFF = 2'd2,
      EV_PITCH     = 2'd3
   } event_kind_type;

   typedef enum logic [1:0] {
      POS_STATUS = 2'd0,
      POS_FIRST  = 2'd1,
      POS_SECOND = 2'd2
   } position_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } byte_pass_type;

   typedef struct packed {
      logic           valid;
      event_kind_type kind;
      logic [2:0]     voice;
      logic [7:0]     number;
      logic [7:0]     amount;
   } event_type;

   // zero based midi channel of voices one to four and the drum voice
   localparam logic [3:0] CHAN_ROWS [CHAN_SETS][MAP_VOICES] = '{
      '{4'd0,  4'd1,  4'd2,  4'd3,  4'd9},
      '{4'd0,  4'd1,  4'd2,  4'd3,  4'd4},
      '{4'd4,  4'd5,  4'd6,  4'd7,  4'd8},
      '{4'd11, 4'd12, 4'd13, 4'd14, 4'd15}
   };

   // voice of a status byte's channel, 0 when unmapped, first match wins
   function automatic logic [2:0] map_voice(input chan_set_type set,
                                            input logic [7:0] status);
      logic [2:0] v;
      v = 3'd0;
      for (int k = MAP_VOICES - 1; k >= 0; k--) begin
         if (CHAN_ROWS[set][k] == status[3:0]) begin
            v = 3'(k + 1);
         end
      end
      return v;
   endfunction

endpackage

/* hw/rtl/midi_message_parser.sv */
// ----------------------------------------------------------------------------
// midi_message_parser: midi channel message parser with running status
// turns a stream of received link bytes into note, controller, all sound
// off and pitch wheel events, each tagged with a mapped voice
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall rx_byte, one link byte
//   rsp      out        rsp_valid/rsp_stall event_kind, voice, number, amount
//   csr      in         csr_valid/csr_ready channel_set, mapping row select
//
// one byte is taken every cycle while req_stall is low; the message state
// registers close their own loop, so the rate is one transaction per clock
// while nothing stalls; bytes pass the input, then the result register
// reset is synchronous and active high; it clears all parse state and
// channel_set, and the csr channel is always ready
// a stalled result holds; the input register keeps taking bytes until a
// byte waits behind a stalled result, then req_stall rises
// ----------------------------------------------------------------------------
module midi_message_parser
   import mmp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // input byte channel
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [7:0]   req_rx_byte,
   // event channel
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [1:0]   rsp_event_kind,
   output logic [2:0]   rsp_voice,
   output logic [7:0]   rsp_number,
   output logic [7:0]   rsp_amount,
   // configuration write channel
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_channel_set
);

   // configuration register
   chan_set_type  channel_set_ff;

   // input register
   logic          in_valid_ff, in_valid_in;
   logic [7:0]    in_byte_ff;

   // result register
   event_type     rsp_ff;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          advance;
   logic          step;
   logic          take_req;
   byte_pass_type pass;
   event_type     ev;

   // the held byte moves on when the result slot is free or being emptied
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign take_req  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take_req) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = step && ev.valid;
      end
   end

   // escape and filler handling
   mmp_byte_filter u_filter (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .pass    (pass)
   );

   // running status and event decode
   mmp_assembler u_assembler (
      .clock       (clock),
      .reset       (reset),
      .pass        (pass),
      .channel_set (channel_set_ff),
      .ev          (ev)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_set_ff <= 2'd0;
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            channel_set_ff <= csr_channel_set;
         end
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (take_req) begin
         in_byte_ff <= req_rx_byte;
      end
      if (step && ev.valid) begin
         rsp_ff <= ev;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_kind = rsp_ff.kind;
   assign rsp_voice      = rsp_ff.voice;
   assign rsp_number     = rsp_ff.number;
   assign rsp_amount     = rsp_ff.amount;

`ifndef ASSERT_OFF
   // a byte held behind a stalled result stays put
   a_hold_byte: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> in_valid_ff && $stable(in_byte_ff))
      else $error("held input byte lost or changed");

   // input side only stalls when a result waits
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff && rsp_stall)
      else $error("input stalled without a waiting result");

   // pitch is clamped to 128
   a_pitch_clamp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_kind == EV_PITCH) |-> rsp_amount <= 8'd128)
      else $error("pitch amount above clamp");

   // all sound off only for its two controllers
   a_sound_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_kind == EV_SOUND_OFF) |->
         (rsp_number == CC_SOUND_OFF || rsp_number == CC_NOTES_OFF))
      else $error("all sound off with wrong controller");

   // mapped voice stays in range
   a_voice_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_voice <= 3'd5)
      else $error("voice out of range");
`endif

endmodule

/* hw/rtl/mmp_byte_filter.sv */
// ----------------------------------------------------------------------------
// mmp_byte_filter: link byte unescaping
// handles the escape byte, drops fillers and realtime bytes
// ----------------------------------------------------------------------------
module mmp_byte_filter
   import mmp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  logic [7:0]    rx_byte,
   output byte_pass_type pass
);

   logic escape_ff;
   logic escape_in;

   always_comb begin
      escape_in  = escape_ff;
      pass.valid = 1'b0;
      pass.data  = rx_byte;
      if (step) begin
         if (!escape_ff && rx_byte == BYTE_ESCAPE) begin
            escape_in = 1'b1;
         end else if (!escape_ff && rx_byte == BYTE_FILLER) begin
            escape_in = 1'b0;
         end else begin
            escape_in  = 1'b0;
            pass.valid = (rx_byte & REALTIME_MASK) != REALTIME_MASK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_ff <= 1'b0;
      end else begin
         escape_ff <= escape_in;
      end
   end

endmodule

/* hw/rtl/mmp_assembler.sv */
// ----------------------------------------------------------------------------
// mmp_assembler: channel message assembly
// running status, voice mapping and event decode
// ----------------------------------------------------------------------------
module mmp_assembler
   import mmp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  byte_pass_type pass,
   input  chan_set_type  channel_set,
   output event_type     ev
);

   position_type pos_ff, pos_in;
   logic [7:0]   status_ff, status_in;
   logic [7:0]   first_ff, first_in;
   logic [2:0]   voice_ff, voice_in;
   logic [7:0]   running_ff, running_in;

   logic [7:0]   st;
   logic         drop;
   position_type next_pos;
   logic [15:0]  pitch;
   logic [15:0]  pitch_clamped;
   logic [7:0]   r;

   assign r             = pass.data;
   assign pitch         = {1'b0, r, 7'd0} + {8'd0, first_ff};
   assign pitch_clamped = (pitch > PITCH_LIMIT) ? PITCH_LIMIT : pitch;

   always_comb begin
      pos_in     = pos_ff;
      status_in  = status_ff;
      first_in   = first_ff;
      voice_in   = voice_ff;
      running_in = running_ff;
      st         = r;
      drop       = 1'b0;
      next_pos   = POS_FIRST;
      ev.valid   = 1'b0;
      ev.kind    = EV_NOTE;
      ev.voice   = voice_ff;
      ev.number  = first_ff;
      ev.amount  = r;
      if (pass.valid) begin
         unique case (pos_ff)
            POS_STATUS: begin
               if (!r[7]) begin
                  if (running_ff != ST_NONE) begin
                     st       = running_ff;
                     first_in = r;
                     next_pos = POS_SECOND;
                  end else begin
                     drop = 1'b1;
                  end
               end
               if (!drop) begin
                  if (st <= ST_LAST_CHAN) begin
                     running_in = st;
                  end else begin
                     running_in = ST_NONE;
                     drop       = 1'b1;
                  end
               end
               voice_in  = map_voice(channel_set, st);
               status_in = st & 8'hF0;
               if (drop) begin
                  pos_in = POS_STATUS;
               end else if (next_pos == POS_SECOND &&
                            (status_in == ST_PROGRAM || status_in == ST_PRESSURE)) begin
                  pos_in = POS_STATUS;
               end else begin
                  pos_in = next_pos;
               end
            end
            POS_FIRST: begin
               first_in = r;
               if (status_ff == ST_PROGRAM || status_ff == ST_PRESSURE) begin
                  pos_in = POS_STATUS;
               end else begin
                  pos_in = POS_SECOND;
               end
            end
            default: begin
               // second data byte completes the message
               pos_in = POS_STATUS;
               if (status_ff == ST_NOTE_OFF || status_ff == ST_NOTE_ON) begin
                  ev.valid  = 1'b1;
                  ev.kind   = EV_NOTE;
                  ev.amount = (status_ff == ST_NOTE_OFF) ? 8'd0 : r;
               end else if (status_ff == ST_CONTROL) begin
                  ev.valid = 1'b1;
                  ev.kind  = (first_ff == CC_SOUND_OFF || first_ff == CC_NOTES_OFF) ?
                             EV_SOUND_OFF : EV_CONTROL;
               end else if (status_ff == ST_PITCH) begin
                  ev.valid  = 1'b1;
                  ev.kind   = EV_PITCH;
                  ev.amount = pitch_clamped[14:7];
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= POS_STATUS;
         status_ff  <= 8'd0;
         first_ff   <= 8'd0;
         voice_ff   <= 3'd0;
         running_ff <= ST_NONE;
      end else begin
         pos_ff     <= pos_in;
         status_ff  <= status_in;
         first_ff   <= first_in;
         voice_ff   <= voice_in;
         running_ff <= running_in;
      end
   end

endmodule

/* tb/tb_midi_message_parser.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_midi_message_parser: self-checking bench of the midi message parser
// link bytes are pushed through the req channel in random bursts while the
// rsp side stalls on its own patterns; a scoreboard predicts every event from
// the byte stream and checks each event transaction field by field
// ----------------------------------------------------------------------------
module tb_midi_message_parser;
   import mmp_pkg::*;

   localparam int HOLD_CYCLES    = 200;   // long receiver hold-off
   localparam int SETTLE_CYCLES  = 6;     // covers the input and result registers
   localparam int IDLE_LIMIT     = 3000;  // watchdog, cycles with no transaction
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 210;

   // one expected event
   typedef struct {
      event_kind_type kind;
      logic [2:0]     voice;
      logic [7:0]     number;
      logic [7:0]     amount;
   } midi_event_type;

   // --------------------------------------------------------------------------
   // scoreboard: follows the parse state byte by byte and keeps the events
   // that are still owed by the block
   // --------------------------------------------------------------------------
   class event_tracker;
      chan_set_type   channel_set;
      bit             escape_pending;
      position_type   byte_pos;
      logic [7:0]     held_status;
      logic [7:0]     first_data;
      logic [2:0]     held_voice;
      logic [7:0]     running_status;
      int             voice_channel [4][5];
      midi_event_type pending_events [$];
      int             error_count;

      function new();
         voice_channel = '{'{1, 2, 3, 4, 10}, '{1, 2, 3, 4, 5},
                           '{5, 6, 7, 8, 9}, '{12, 13, 14, 15, 16}};
         channel_set    = '0;
         escape_pending = 1'b0;
         byte_pos       = POS_STATUS;
         held_status    = '0;
         first_data     = '0;
         held_voice     = '0;
         running_status = ST_NONE;
         error_count    = 0;
      endfunction

      // voice of the channel in a status byte, 0 when the row has no match
      function logic [2:0] voice_of(logic [7:0] status);
         int          chan;
         logic [2:0]  v;
         chan = int'(status[3:0]) + 1;
         v    = 3'd0;
         for (int k = 0; k < 5; k++) begin
            if (v == 3'd0 && voice_channel[channel_set][k] == chan) begin
               v = 3'(k + 1);
            end
         end
         return v;
      endfunction

      function bit one_data_byte(logic [7:0] status);
         return status == ST_PROGRAM || status == ST_PRESSURE;
      endfunction

      // one accepted link byte
      function void note_byte(logic [7:0] b);
         logic [7:0]     st;
         bit             drop;
         position_type   nxt;
         int unsigned    pitch;
         midi_event_type ev;
         if (!escape_pending && b == BYTE_ESCAPE) begin
            escape_pending = 1'b1;
            return;
         end
         if (!escape_pending && b == BYTE_FILLER) begin
            return;
         end
         escape_pending = 1'b0;
         if ((b & REALTIME_MASK) == REALTIME_MASK) begin
            return;
         end
         case (byte_pos)
            POS_STATUS: begin
               st   = b;
               drop = 1'b0;
               nxt  = POS_FIRST;
               if (b < 8'h80) begin
                  if (running_status != ST_NONE) begin
                     st         = running_status;
                     first_data = b;
                     nxt        = POS_SECOND;
                  end else begin
                     drop = 1'b1;
                  end
               end
               if (!drop) begin
                  if (st <= ST_LAST_CHAN) begin
                     running_status = st;
                  end else begin
                     running_status = ST_NONE;
                     drop           = 1'b1;
                  end
               end
               held_voice  = voice_of(st);
               held_status = st & 8'hF0;
               byte_pos    = drop ? POS_STATUS : nxt;
               if (byte_pos == POS_SECOND && one_data_byte(held_status)) begin
                  byte_pos = POS_STATUS;
               end
            end
            POS_FIRST: begin
               first_data = b;
               byte_pos   = one_data_byte(held_status) ? POS_STATUS : POS_SECOND;
            end
            default: begin
               byte_pos  = POS_STATUS;
               ev.voice  = held_voice;
               ev.number = first_data;
               if (held_status == ST_NOTE_OFF || held_status == ST_NOTE_ON) begin
                  ev.kind   = EV_NOTE;
                  ev.amount = (held_status == ST_NOTE_OFF) ? 8'd0 : b;
                  pending_events.push_back(ev);
               end else if (held_status == ST_CONTROL) begin
                  ev.kind   = (first_data == CC_SOUND_OFF || first_data == CC_NOTES_OFF)
                              ? EV_SOUND_OFF : EV_CONTROL;
                  ev.amount = b;
                  pending_events.push_back(ev);
               end else if (held_status == ST_PITCH) begin
                  pitch = 128 * b + first_data;
                  if (pitch > PITCH_LIMIT) begin
                     pitch = PITCH_LIMIT;
                  end
                  ev.kind   = EV_PITCH;
                  ev.amount = 8'(pitch >> 7);
                  pending_events.push_back(ev);
               end
            end
         endcase
      endfunction

      // one accepted event transaction against the oldest expectation
      function void check_event(logic [1:0] kind, logic [2:0] voice,
                                logic [7:0] number, logic [7:0] amount);
         midi_event_type want;
         if (pending_events.size() == 0) begin
            $error("unexpected event: kind %0d voice %0d number %0h amount %0h",
                   kind, voice, number, amount);
            error_count++;
            return;
         end
         want = pending_events.pop_front();
         if (kind !== want.kind) begin
            $error("event_kind: expected %0d, actual %0d", want.kind, kind);
            error_count++;
         end
         if (voice !== want.voice) begin
            $error("voice: expected %0d, actual %0d", want.voice, voice);
            error_count++;
         end
         if (number !== want.number) begin
            $error("number: expected %0h, actual %0h", want.number, number);
            error_count++;
         end
         if (amount !== want.amount) begin
            $error("amount: expected %0h, actual %0h", want.amount, amount);
            error_count++;
         end
      endfunction
   endclass

   // --------------------------------------------------------------------------
   // signals
   // --------------------------------------------------------------------------
   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   logic [7:0]   req_rx_byte;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   logic [1:0]   rsp_event_kind;
   logic [2:0]   rsp_voice;
   logic [7:0]   rsp_number;
   logic [7:0]   rsp_amount;
   logic         csr_valid;
   logic         csr_ready;
   logic [1:0]   csr_channel_set;

   event_tracker tracker;
   logic [7:0]   link_bytes [$];     // bytes waiting to go out on the link
   int           stream_items;       // bytes that the parser actually looks at
   bit           gen_running;        // generator's guess of a live running status

   // sender shaping, set by the main sequence
   int           burst_max;
   int           gap_max;
   int           burst_left;

   // receiver shaping; stall_mode and hold_asked are written by the main
   // sequence only, the rest by the stall process only
   int           stall_mode;
   int           hold_asked;
   int           hold_seen  = 0;
   int           hold_left  = 0;
   int           stall_tick = 0;
   int           stall_run  = 0;

   midi_message_parser u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_voice       (rsp_voice),
      .rsp_number      (rsp_number),
      .rsp_amount      (rsp_amount),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_channel_set (csr_channel_set)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // --------------------------------------------------------------------------
   // event side: check every accepted event transaction
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         tracker.check_event(rsp_event_kind, rsp_voice, rsp_number, rsp_amount);
      end
   end

   // receiver stall patterns, with a long hold-off on request
   always @(posedge clock) begin
      stall_tick++;
      if (hold_seen != hold_asked) begin
         hold_seen = hold_asked;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            1: rsp_stall <= ($urandom_range(0, 2) == 0);
            2: rsp_stall <= ((stall_tick % 7) < 3);
            3: begin
               // occasional runs of stall, otherwise free flowing
               if (stall_run > 0) begin
                  stall_run--;
                  rsp_stall <= 1'b1;
               end else if ($urandom_range(0, 19) == 0) begin
                  stall_run = $urandom_range(5, 30);
                  rsp_stall <= 1'b1;
               end else begin
                  rsp_stall <= 1'b0;
               end
            end
            default: rsp_stall <= 1'b0;
         endcase
      end
   end

   // watchdog: too long with no transaction on any channel ends the run
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
             || (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("TEST FAILED");
      $finish;
   end

   // --------------------------------------------------------------------------
   // link drivers
   // --------------------------------------------------------------------------
   // one byte transaction; the payload holds while stalled
   task automatic send_byte(input logic [7:0] b);
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      tracker.note_byte(b);
   endtask

   // drop valid for a gap of length n, nothing when n is zero
   task automatic hold_sender(input int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // send the queued bytes in bursts with random gaps between them
   task automatic send_stream();
      logic [7:0] b;
      while (link_bytes.size() > 0) begin
         b = link_bytes.pop_front();
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, burst_max);
            hold_sender($urandom_range(0, gap_max));
         end
         burst_left--;
         send_byte(b);
      end
   endtask

   // sender pauses until every owed event has come, then the pipe settles
   task automatic drain_events();
      hold_sender(1);
      while (tracker.pending_events.size() > 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mapping row write, only with the parser idle
   task automatic write_channel_set(input chan_set_type v);
      csr_valid       <= 1'b1;
      csr_channel_set <= v;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid <= 1'b0;
      tracker.channel_set = v;
   endtask

   // --------------------------------------------------------------------------
   // byte stream generation
   // --------------------------------------------------------------------------
   // queue a byte, now and then with link noise in front or an escape
   task automatic put_byte(input logic [7:0] b);
      case ($urandom_range(0, 39))
         0: link_bytes.push_back(BYTE_FILLER);
         1: link_bytes.push_back(8'($urandom_range(8'hF8, 8'hFD)));
         2: begin
            link_bytes.push_back(BYTE_ESCAPE);
            link_bytes.push_back($urandom_range(0, 1) ? BYTE_FILLER : BYTE_ESCAPE);
         end
         3: link_bytes.push_back(BYTE_ESCAPE);   // escaped byte still parses
         default: ;
      endcase
      link_bytes.push_back(b);
      stream_items++;
   endtask

   // data byte, mostly in range, at times the extremes or a status byte
   function automatic logic [7:0] data_value();
      case ($urandom_range(0, 19))
         0:       return 8'h00;
         1:       return 8'h7F;
         2:       return 8'($urandom_range(8'h80, 8'hF7));
         default: return 8'($urandom_range(0, 127));
      endcase
   endfunction

   // one channel message with random content, sometimes under running status
   task automatic put_message();
      logic [7:0] status;
      logic [7:0] first;
      logic [7:0] second;
      status = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)};
      first  = data_value();
      second = data_value();
      if ((status & 8'hF0) == ST_CONTROL && $urandom_range(0, 3) == 0) begin
         first = $urandom_range(0, 1) ? CC_SOUND_OFF : CC_NOTES_OFF;
      end
      if ((status & 8'hF0) == ST_PITCH && $urandom_range(0, 4) == 0) begin
         first  = 8'h7F;
         second = $urandom_range(0, 1) ? 8'h7F : 8'h40;
      end
      if (!gen_running || $urandom_range(0, 2) != 0) begin
         put_byte(status);
      end
      gen_running = 1'b1;
      if ($urandom_range(0, 29) == 0) begin
         return;   // broken message, cut after the status
      end
      put_byte(first);
      if ((status & 8'hF0) != ST_PROGRAM && (status & 8'hF0) != ST_PRESSURE) begin
         put_byte(second);
      end
   endtask

   // noise: raw bytes, system common with trailing data, orphan data
   task automatic put_noise();
      case ($urandom_range(0, 2))
         0: put_byte(8'($urandom));
         1: begin
            put_byte(8'($urandom_range(8'hF0, 8'hF7)));
            gen_running = 1'b0;
            repeat ($urandom_range(0, 3)) put_byte(8'($urandom_range(0, 127)));
         end
         default: put_byte(8'($urandom_range(0, 127)));
      endcase
   endtask

   // --------------------------------------------------------------------------
   // main sequence
   // --------------------------------------------------------------------------
   initial begin
      chan_set_type phase_sets [PHASES];
      phase_sets = '{2'd0, 2'd3, 2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd1};

      tracker         = new();
      stream_items    = 0;
      gen_running     = 1'b0;
      burst_max       = 4;
      gap_max         = 2;
      burst_left      = 0;
      stall_mode      = 0;
      hold_asked      = 0;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_rx_byte     <= 8'h00;
      csr_valid       <= 1'b0;
      csr_channel_set <= 2'd0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed bytes under the reset mapping row: orphan data, note on and
      // its running status, note off on the drum channel, all sound off by
      // both controllers, program and pressure, aftertouch, pitch on an
      // unmapped channel, pitch clamp via a status byte in a data position,
      // filler, escaped filler, escaped status, realtime, system common
      link_bytes = '{8'h45,
                     8'h90, 8'h3C, 8'h7F, 8'h00, 8'h00,
                     8'h89, 8'h7F, 8'h40,
                     8'hB1, 8'h78, 8'h10, 8'h7B, 8'h7F,
                     8'hC2, 8'h05, 8'h06, 8'hD3, 8'h7F,
                     8'hA0, 8'h01, 8'h02,
                     8'hE4, 8'h7F, 8'h7F, 8'hE0, 8'h7F, 8'hF7,
                     8'hFE, 8'hFF, 8'hFE, 8'hFF, 8'h90, 8'h3C, 8'hF8, 8'h95,
                     8'hF2, 8'h01};
      send_stream();
      drain_events();

      // random phases, each under its own mapping row and idling mix
      for (int phase = 0; phase < PHASES; phase++) begin
         write_channel_set(phase_sets[phase]);
         stall_mode = phase % 4;
         gap_max    = (phase % 3 == 0) ? 0 : 3 + phase;
         burst_max  = 1 + $urandom_range(0, 15);
         stream_items = 0;
         while (stream_items < PHASE_ITEMS) begin
            if ($urandom_range(0, 6) == 0) begin
               put_noise();
            end else begin
               put_message();
            end
         end
         if (phase == 2 || phase == 6) begin
            // receiver holds off while the sender keeps offering bytes
            hold_asked++;
         end
         send_stream();
         drain_events();
      end

      if (tracker.pending_events.size() != 0) begin
         $error("%0d events never arrived", tracker.pending_events.size());
         tracker.error_count++;
      end
      if (tracker.error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

/* midi_message_parser.f */
hw/rtl/mmp_pkg.sv
hw/rtl/mmp_byte_filter.sv
hw/rtl/mmp_assembler.sv
hw/rtl/midi_message_parser.sv
tb/tb_midi_message_parser.sv
